// ----- rtl/swbe_pkg.sv -----
// Shared types and constants for the sliding-window bandwidth estimator.
package swbe_pkg;

    // Default ring depth.
    localparam int HISTORY_DEPTH_DEF = 64;

    // Field widths.
    localparam int BYTES_W     = 32;
    localparam int DELAY_W     = 32;
    localparam int TIME_W      = 48;
    localparam int SUM_W       = 48;
    localparam int RATE_W      = 32;
    localparam int WIN_W       = 6;
    localparam int PERIOD_W    = 16;
    localparam int PERIOD_US_W = 26;
    localparam int IN_DATA_W   = 112;
    localparam int OUT_DATA_W  = 64;

    // Scaling constants.
    localparam int US_PER_MS      = 1000;
    localparam int KBPS_DIV       = 1000;
    localparam int BYTE_SHIFT     = 3;
    localparam int MIN_ENTRIES    = 2;
    localparam logic [SUM_W-1:0] MIN_BYTES = 48'd65536;

    // Bit-serial divider geometry.
    localparam int DIVIDEND_W = 72;
    localparam int DIVISOR_W  = 48;
    localparam int QUOT_W     = 48;
    localparam int DIV_STEP_W = 7;
    localparam int DIV_STEPS  = 72;

    // Bits per second are bytes * 15625 * 512 over microseconds.
    localparam int SCALE_K      = 15625;
    localparam int SCALE_W      = 14;
    localparam int SCALE_SHIFT  = 9;
    localparam int PROD_W       = 62;
    localparam int SCALE_STEP_W = 4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW = 1'b0,
        REG_PERIOD = 1'b1
    } cfg_reg_t;

    // Commands from the sequencer to the window store.
    typedef struct packed {
        logic wr;
        logic rd;
        logic ev;
    } win_cmd_t;

    // Divider status.
    typedef struct packed {
        logic done;
        logic over;
    } div_status_t;

endpackage

// ----- rtl/swbe_divider.sv -----
// Restoring divider, one quotient bit per cycle, most significant bit first.
// The low quotient bits are kept; over flags any quotient bit at or above
// the rate width, which the caller uses to saturate.
module swbe_divider (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [swbe_pkg::DIVIDEND_W-1:0]      dividend,
    input  logic [swbe_pkg::DIVISOR_W-1:0]       divisor,
    output swbe_pkg::div_status_t                status,
    output logic [swbe_pkg::QUOT_W-1:0]          quotient
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [swbe_pkg::DIV_STEP_W-1:0]     step_reg;
    logic                                over_reg;
    logic [swbe_pkg::DIVIDEND_W-1:0]     num_reg;
    logic [swbe_pkg::DIVISOR_W-1:0]      den_reg;
    logic [swbe_pkg::DIVISOR_W-1:0]      rem_reg;
    logic [swbe_pkg::QUOT_W-1:0]         quot_reg;

    logic [swbe_pkg::DIVISOR_W:0]        rem_shift;
    logic [swbe_pkg::DIVISOR_W:0]        rem_sub;
    logic                                fits;
    logic [swbe_pkg::DIVISOR_W-1:0]      rem_next;

    // One trial subtraction per cycle.
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[swbe_pkg::DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, den_reg};
        rem_sub   = rem_shift - {1'b0, den_reg};
        rem_next  = fits ? rem_sub[swbe_pkg::DIVISOR_W-1:0]
                         : rem_shift[swbe_pkg::DIVISOR_W-1:0];
    end

    // Step counter and handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= swbe_pkg::DIV_STEP_W'(swbe_pkg::DIV_STEPS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == swbe_pkg::DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= dividend;
            den_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
            over_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[swbe_pkg::DIVIDEND_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[swbe_pkg::QUOT_W-2:0], fits};
            if (fits && (step_reg > swbe_pkg::DIV_STEP_W'(swbe_pkg::RATE_W)))
            begin
                over_reg <= 1'b1;
            end
        end
    end

    assign status.done = done_reg;
    assign status.over = over_reg;
    assign quotient    = quot_reg;

endmodule

// ----- rtl/swbe_scaler.sv -----
// Shift-and-add multiplier by the fixed bits-per-second factor,
// one multiplier bit per cycle, least significant bit first.
module swbe_scaler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [swbe_pkg::SUM_W-1:0]      operand,
    output logic                            done,
    output logic [swbe_pkg::PROD_W-1:0]     product
);

    logic                                   busy_reg;
    logic                                   done_reg;
    logic [swbe_pkg::SCALE_STEP_W-1:0]      step_reg;
    logic [swbe_pkg::PROD_W-1:0]            mcand_reg;
    logic [swbe_pkg::SCALE_W-1:0]           mier_reg;
    logic [swbe_pkg::PROD_W-1:0]            acc_reg;

    // Step counter and handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= swbe_pkg::SCALE_STEP_W'(swbe_pkg::SCALE_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == swbe_pkg::SCALE_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Accumulate the shifted operand for each set bit of the factor.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= swbe_pkg::PROD_W'(operand);
            mier_reg  <= swbe_pkg::SCALE_W'(swbe_pkg::SCALE_K);
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (mier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg <= {mcand_reg[swbe_pkg::PROD_W-2:0], 1'b0};
            mier_reg  <= {1'b0, mier_reg[swbe_pkg::SCALE_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- rtl/swbe_window.sv -----
// Ring of recent measurements with running sums of bytes and delay.
module swbe_window #(
    parameter int HISTORY_DEPTH = swbe_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  swbe_pkg::win_cmd_t                  cmd,
    input  logic [swbe_pkg::BYTES_W-1:0]        wr_bytes,
    input  logic [swbe_pkg::DELAY_W-1:0]        wr_delay,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0]  count,
    output logic [swbe_pkg::SUM_W-1:0]          sum_bytes,
    output logic [swbe_pkg::SUM_W-1:0]          sum_delay
);

    localparam int IW    = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    logic [swbe_pkg::BYTES_W-1:0]   entry_bytes_reg [HISTORY_DEPTH];
    logic [swbe_pkg::DELAY_W-1:0]   entry_delay_reg [HISTORY_DEPTH];
    logic [swbe_pkg::BYTES_W-1:0]   rd_bytes_reg;
    logic [swbe_pkg::DELAY_W-1:0]   rd_delay_reg;

    logic [IW-1:0]                  oldest_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [swbe_pkg::SUM_W-1:0]     sum_bytes_reg;
    logic [swbe_pkg::SUM_W-1:0]     sum_delay_reg;

    logic [IW:0]                    slot_sum;
    logic [IW:0]                    slot_wrap;
    logic [IW-1:0]                  slot;
    logic [IW-1:0]                  oldest_next;

    // Slot of the new entry is oldest plus count, modulo the depth.
    always_comb
    begin
        slot_sum  = {1'b0, oldest_reg} + (IW+1)'(count_reg);
        slot_wrap = (slot_sum >= (IW+1)'(HISTORY_DEPTH))
                  ? slot_sum - (IW+1)'(HISTORY_DEPTH) : slot_sum;
        slot      = slot_wrap[IW-1:0];
        oldest_next = (oldest_reg == IW'(HISTORY_DEPTH - 1))
                    ? '0 : oldest_reg + 1'b1;
    end

    // Entry memory: one write port, one registered read port at the oldest slot.
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            entry_bytes_reg[slot] <= wr_bytes;
            entry_delay_reg[slot] <= wr_delay;
        end
        if (cmd.rd)
        begin
            rd_bytes_reg <= entry_bytes_reg[oldest_reg];
            rd_delay_reg <= entry_delay_reg[oldest_reg];
        end
    end

    // Ring pointers and running sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg    <= '0;
            count_reg     <= '0;
            sum_bytes_reg <= '0;
            sum_delay_reg <= '0;
        end
        else if (cmd.wr)
        begin
            sum_bytes_reg <= sum_bytes_reg + swbe_pkg::SUM_W'(wr_bytes);
            sum_delay_reg <= sum_delay_reg + swbe_pkg::SUM_W'(wr_delay);
            count_reg     <= count_reg + 1'b1;
        end
        else if (cmd.ev)
        begin
            sum_bytes_reg <= sum_bytes_reg - swbe_pkg::SUM_W'(rd_bytes_reg);
            sum_delay_reg <= sum_delay_reg - swbe_pkg::SUM_W'(rd_delay_reg);
            oldest_reg    <= oldest_next;
            count_reg     <= count_reg - 1'b1;
        end
    end

    assign count     = count_reg;
    assign sum_bytes = sum_bytes_reg;
    assign sum_delay = sum_delay_reg;

endmodule

// ----- rtl/sliding_window_bandwidth_estimator_core.sv -----
// Channel   Direction  Signals                               Contents
// s_axis    in         s_axis_tvalid/tready/tdata[111:0]    one measurement word
// m_axis    out        m_axis_tvalid/tready/tdata[63:0]/tuser  one estimate word
// cfg       in         cfg_valid/ready/index[0:0]/data[15:0]  register write
//
// One word is processed at a time: input is not ready again until the estimate for
// the last word has been loaded into the output register. Processing time is set
// mostly by the 14-step scaler and the 72-step divider; a kbps update adds two
// divider passes, and a word without an estimate skips the scaler and bps division.
// Reset clears pointers, sums, sample time and kbps value, not the entry memory.
// A stalled output holds its word while the next measurement is processed.
module sliding_window_bandwidth_estimator_core #(
    parameter int HISTORY_DEPTH = swbe_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [31:0] byte_count, [63:32] delay_micros, [111:64] time_now_micros
    input  logic [swbe_pkg::IN_DATA_W-1:0]          s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // [31:0] rate_bps, [63:32] rate_kbps
    output logic [swbe_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // [0] estimate_valid
    output logic [0:0]                              m_axis_tuser,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [swbe_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [swbe_pkg::PERIOD_W-1:0]           cfg_data
);

    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > swbe_pkg::WIN_W) ? CNT_W : swbe_pkg::WIN_W;
    localparam int WIN_MAX = HISTORY_DEPTH - 1;
    localparam int PAD_K   = swbe_pkg::DIVIDEND_W - swbe_pkg::SUM_W - swbe_pkg::BYTE_SHIFT;
    localparam int PAD_T   = swbe_pkg::DIVIDEND_W - swbe_pkg::SUM_W;
    localparam int PAD_B   = swbe_pkg::DIVIDEND_W - swbe_pkg::PROD_W - swbe_pkg::SCALE_SHIFT;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_WRITE = 11'b000_0000_0010,
        S_READ  = 11'b000_0000_0100,
        S_EVICT = 11'b000_0000_1000,
        S_CHECK = 11'b000_0001_0000,
        S_DIVT  = 11'b000_0010_0000,
        S_DIVK  = 11'b000_0100_0000,
        S_RATE  = 11'b000_1000_0000,
        S_MUL   = 11'b001_0000_0000,
        S_DIVB  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t                                 state_reg;
    state_t                                 state_next;

    logic [swbe_pkg::BYTES_W-1:0]           bytes_reg;
    logic [swbe_pkg::DELAY_W-1:0]           delay_reg;
    logic [swbe_pkg::TIME_W-1:0]            now_reg;
    logic [swbe_pkg::TIME_W-1:0]            last_sample_reg;
    logic [swbe_pkg::RATE_W-1:0]            kbps_reg;
    logic [swbe_pkg::RATE_W-1:0]            bps_reg;
    logic                                   est_valid_reg;
    logic [swbe_pkg::WIN_W-1:0]             window_cfg_reg;
    logic [swbe_pkg::PERIOD_US_W-1:0]       period_us_reg;

    logic                                   out_valid_reg;
    logic                                   out_est_reg;
    logic [swbe_pkg::RATE_W-1:0]            out_bps_reg;
    logic [swbe_pkg::RATE_W-1:0]            out_kbps_reg;

    swbe_pkg::win_cmd_t                     win_cmd;
    logic [CNT_W-1:0]                       win_count;
    logic [swbe_pkg::SUM_W-1:0]             sum_bytes;
    logic [swbe_pkg::SUM_W-1:0]             sum_delay;

    logic                                   div_start;
    logic [swbe_pkg::DIVIDEND_W-1:0]        div_dividend;
    logic [swbe_pkg::DIVISOR_W-1:0]         div_divisor;
    swbe_pkg::div_status_t                  div_status;
    logic [swbe_pkg::QUOT_W-1:0]            div_quot;

    logic                                   mul_start;
    logic                                   mul_done;
    logic [swbe_pkg::PROD_W-1:0]            mul_prod;

    logic [CMP_W-1:0]                       win_ext;
    logic [CMP_W-1:0]                       win_eff;
    logic                                   evict;
    logic                                   take_sample;
    logic                                   est_valid;
    logic                                   in_accept;
    logic                                   out_free;
    logic [swbe_pkg::RATE_W-1:0]            div_sat;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Window limit, sample-period test, estimate qualification.
    always_comb
    begin
        win_ext = CMP_W'(window_cfg_reg);
        win_eff = (win_ext > CMP_W'(WIN_MAX)) ? CMP_W'(WIN_MAX) : win_ext;
        evict   = CMP_W'(win_count) > win_eff;
        take_sample = {1'b0, now_reg} >=
                      ({1'b0, last_sample_reg} + (swbe_pkg::TIME_W+1)'(period_us_reg));
        est_valid = (win_count >= CNT_W'(swbe_pkg::MIN_ENTRIES))
                 && (sum_bytes >= swbe_pkg::MIN_BYTES);
        div_sat = div_status.over ? '1 : div_quot[swbe_pkg::RATE_W-1:0];
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        win_cmd      = '0;
        div_start    = 1'b0;
        mul_start    = 1'b0;
        div_dividend = {PAD_T'(0), sum_delay};
        div_divisor  = swbe_pkg::DIVISOR_W'(swbe_pkg::KBPS_DIV);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                win_cmd.wr = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                win_cmd.rd = 1'b1;
                state_next = evict ? S_EVICT : S_RATE;
            end
            S_EVICT:
            begin
                win_cmd.ev = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (take_sample && (last_sample_reg != '0))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVT;
                end
                else
                begin
                    state_next = S_RATE;
                end
            end
            S_DIVT:
            begin
                div_dividend = {PAD_K'(0), sum_bytes, swbe_pkg::BYTE_SHIFT'(0)};
                div_divisor  = div_quot;
                if (div_status.done)
                begin
                    if (div_quot == '0)
                    begin
                        state_next = S_RATE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIVK;
                    end
                end
            end
            S_DIVK:
            begin
                if (div_status.done)
                begin
                    state_next = S_RATE;
                end
            end
            S_RATE:
            begin
                if (est_valid && (sum_delay != '0))
                begin
                    mul_start  = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                div_dividend = {PAD_B'(0), mul_prod, swbe_pkg::SCALE_SHIFT'(0)};
                div_divisor  = sum_delay;
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVB;
                end
            end
            S_DIVB:
            begin
                if (div_status.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, configuration, sample time and kbps value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_cfg_reg  <= '0;
            period_us_reg   <= '0;
            last_sample_reg <= '0;
            kbps_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (swbe_pkg::cfg_reg_t'(cfg_index))
                    swbe_pkg::REG_WINDOW:
                    begin
                        window_cfg_reg <= cfg_data[swbe_pkg::WIN_W-1:0];
                    end
                    swbe_pkg::REG_PERIOD:
                    begin
                        period_us_reg <= swbe_pkg::PERIOD_US_W'(cfg_data)
                                       * swbe_pkg::PERIOD_US_W'(swbe_pkg::US_PER_MS);
                    end
                endcase
            end

            if ((state_reg == S_CHECK) && take_sample)
            begin
                last_sample_reg <= now_reg;
            end

            if ((state_reg == S_DIVK) && div_status.done)
            begin
                kbps_reg <= div_sat;
            end

            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            bytes_reg <= s_axis_tdata[31:0];
            delay_reg <= s_axis_tdata[63:32];
            now_reg   <= s_axis_tdata[111:64];
        end

        if (state_reg == S_RATE)
        begin
            est_valid_reg <= est_valid;
            bps_reg       <= est_valid ? '1 : '0;
        end
        else if ((state_reg == S_DIVB) && div_status.done)
        begin
            bps_reg <= div_sat;
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            out_est_reg  <= est_valid_reg;
            out_bps_reg  <= bps_reg;
            out_kbps_reg <= kbps_reg;
        end
    end

    swbe_window #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (win_cmd),
        .wr_bytes  (bytes_reg),
        .wr_delay  (delay_reg),
        .count     (win_count),
        .sum_bytes (sum_bytes),
        .sum_delay (sum_delay)
    );

    swbe_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quot)
    );

    swbe_scaler u_scaler (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (sum_bytes),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_kbps_reg, out_bps_reg};
    assign m_axis_tuser  = out_est_reg;

endmodule

// ----- rtl/swbe_checker.sv -----
// Port-level checks for the estimator core.
module swbe_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic [swbe_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [swbe_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input logic [0:0]                           m_axis_tuser,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic [swbe_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input logic [swbe_pkg::PERIOD_W-1:0]        cfg_data
);

    // A stalled output word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

    // Without a qualified estimate the bps field reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == '0)
    else $error("bps nonzero without a valid estimate");

    // The core is busy with each accepted word, so input is not ready right after a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

    // A new result appears only as the core finishes a word and returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready && $past(!s_axis_tready))
    else $error("result appeared outside the end of processing");

endmodule

bind sliding_window_bandwidth_estimator_core swbe_checker u_swbe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    // One measurement word and one estimate word, field by field.
    typedef struct packed {
        logic [31:0] bytes;
        logic [31:0] delay;
        logic [47:0] stamp;
    } meas_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] bps;
        logic [31:0] kbps;
    } rate_t;

    typedef enum logic {
        ROW_CFG,
        ROW_MEAS
    } row_kind_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        row_kind_t           kind;
        swbe_pkg::cfg_reg_t  reg_sel;
        logic [15:0]         reg_val;
        meas_t               m;
        bit                  typed;
        rate_t               want;
    } plan_row_t;

    typedef struct {
        logic [5:0]  window;
        logic [15:0] period;
        idle_mode_t  mode;
        int          items;
    } phase_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [swbe_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [swbe_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic [0:0]                        m_axis_tuser;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [swbe_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [swbe_pkg::PERIOD_W-1:0]     cfg_data = '0;

    // Window model state, mirroring the block after reset.
    logic [31:0] ring_bytes [64];
    logic [31:0] ring_delay [64];
    logic [5:0]  head_slot = '0;
    logic [6:0]  fill = '0;
    logic [47:0] win_bytes = '0;
    logic [47:0] win_delay = '0;
    logic [47:0] sample_stamp = '0;
    logic [31:0] held_kbps = '0;
    logic [5:0]  cfg_window = '0;
    logic [15:0] cfg_period = '0;

    // Expected estimate words in order of acceptance, and the directed rows.
    rate_t       want_fifo [2048];
    int          want_wr = 0;
    int          want_rd = 0;
    plan_row_t   plan [64];
    int          plan_len = 0;
    int          mismatch_count = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    logic [47:0] clock_us = '0;

    phase_t phases [8] = '{
        '{6'd3,  16'd0,     IDLE_NONE,     170},
        '{6'd0,  16'd100,   IDLE_SENDER,   170},
        '{6'd8,  16'd1,     IDLE_RECEIVER, 170},
        '{6'd20, 16'd10,    IDLE_BOTH,     170},
        '{6'd1,  16'd65535, IDLE_NONE,     160},
        '{6'd40, 16'd5,     IDLE_SENDER,   170},
        '{6'd63, 16'd65535, IDLE_RECEIVER, 170},
        '{6'd63, 16'd0,     IDLE_BOTH,     170}
    };

    sliding_window_bandwidth_estimator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Appends a measurement to the window model and returns the estimate word.
    function automatic rate_t advance_window(input meas_t m);
        logic [5:0]      slot;
        logic [47:0]     ms_div;
        logic [63:0]     kb;
        logic [79:0]     scaled;
        longint          gap;
        longint          span;
        rate_t           r;
        // A 6-bit window can never exceed the ring depth minus one.
        slot = head_slot + fill[5:0];
        ring_bytes[slot] = m.bytes;
        ring_delay[slot] = m.delay;
        win_bytes = win_bytes + m.bytes;
        win_delay = win_delay + m.delay;
        fill = fill + 7'd1;
        if (fill > {1'b0, cfg_window})
        begin
            win_bytes = win_bytes - ring_bytes[head_slot];
            win_delay = win_delay - ring_delay[head_slot];
            head_slot = head_slot + 6'd1;
            fill = fill - 7'd1;
            // Time going backwards gives a negative gap and no sample.
            gap = longint'({16'd0, m.stamp}) - longint'({16'd0, sample_stamp});
            span = longint'(cfg_period) * 1000;
            if (gap >= span)
            begin
                // The first sample only records the time; a zero divisor keeps the rate.
                if (sample_stamp != 48'd0)
                begin
                    ms_div = win_delay / 48'd1000;
                    if (ms_div != 48'd0)
                    begin
                        kb = ({16'd0, win_bytes} << 3) / {16'd0, ms_div};
                        held_kbps = (kb > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : kb[31:0];
                    end
                end
                sample_stamp = m.stamp;
            end
        end
        r.ok = (fill >= 7'd2) && (win_bytes >= 48'd65536);
        r.bps = 32'd0;
        if (r.ok)
        begin
            if (win_delay == 48'd0)
            begin
                r.bps = 32'hFFFF_FFFF;
            end
            else
            begin
                scaled = ({32'd0, win_bytes} * 80'd8000000) / {32'd0, win_delay};
                r.bps = (scaled > 80'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
            end
        end
        r.kbps = held_kbps;
        return r;
    endfunction

    // Random measurement: mostly a monotonic clock, some noise with any time at all.
    function automatic meas_t make_meas();
        meas_t       m;
        int unsigned pick;
        int unsigned span;
        logic [31:0] hi;
        logic [47:0] step;
        span = int'(cfg_period) * 1000;
        pick = $urandom_range(9);
        case (pick)
            0:       m.bytes = 32'd0;
            1:       m.bytes = 32'hFFFF_FFFF;
            2, 3, 4: m.bytes = $urandom_range(1500, 0);
            5, 6, 7: m.bytes = $urandom_range(200000, 0);
            default: m.bytes = $urandom;
        endcase
        pick = $urandom_range(9);
        case (pick)
            0:             m.delay = 32'd0;
            1:             m.delay = $urandom_range(999, 0);
            2, 3, 4, 5:    m.delay = $urandom_range(100000, 1000);
            6, 7:          m.delay = $urandom_range(5000000, 0);
            8:             m.delay = $urandom;
            default:       m.delay = 32'hFFFF_FFFF;
        endcase
        if ($urandom_range(99) < 3)
        begin
            hi = $urandom;
            m.stamp = {hi[15:0], $urandom};
        end
        else
        begin
            pick = $urandom_range(9);
            case (pick)
                0:             step = 48'd0;
                1, 2, 3:       step = $urandom_range(2000, 0);
                4, 5, 6, 7:    step = $urandom_range(span * 2 + 1000, span / 2);
                default:       step = $urandom;
            endcase
            clock_us = clock_us + step;
            m.stamp = clock_us;
        end
        return m;
    endfunction

    function automatic void set_mode(input idle_mode_t mode);
        gap_pct = (mode == IDLE_SENDER) ? 54 : (mode == IDLE_BOTH) ? 7 : 0;
        stall_pct = (mode == IDLE_RECEIVER) ? 54 : (mode == IDLE_BOTH) ? 7 : 0;
    endfunction

    function automatic void add_cfg(input swbe_pkg::cfg_reg_t r, input logic [15:0] v);
        plan_row_t row;
        row = '{kind: ROW_CFG, reg_sel: r, reg_val: v, m: '0, typed: 1'b0, want: '0};
        plan[plan_len] = row;
        plan_len++;
    endfunction

    function automatic void add_meas(input logic [31:0] b, input logic [31:0] d,
                                     input logic [47:0] t, input bit typed,
                                     input logic ok, input logic [31:0] bps,
                                     input logic [31:0] kbps);
        plan_row_t row;
        row.kind = ROW_MEAS;
        row.reg_sel = swbe_pkg::REG_WINDOW;
        row.reg_val = '0;
        row.m = '{bytes: b, delay: d, stamp: t};
        row.typed = typed;
        row.want = '{ok: ok, bps: bps, kbps: kbps};
        plan[plan_len] = row;
        plan_len++;
    endfunction

    // Presents one measurement word and records its expected estimate on acceptance.
    task automatic send_meas(input meas_t m, input bit typed, input rate_t want);
        rate_t r;
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata <= {m.stamp, m.delay, m.bytes};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = advance_window(m);
        want_fifo[want_wr] = typed ? want : r;
        want_wr++;
        if (sample_stamp > clock_us)
        begin
            clock_us = sample_stamp;
        end
    endtask

    // Register write; valid stays high so back-to-back writes need no bubble.
    task automatic write_reg(input swbe_pkg::cfg_reg_t r, input logic [15:0] v);
        cfg_index <= r;
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (r == swbe_pkg::REG_WINDOW)
        begin
            cfg_window = v[5:0];
        end
        else
        begin
            cfg_period = v;
        end
    endtask

    // Holds off the sender until every expected estimate has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (want_wr != want_rd)
        begin
            @(posedge clk);
        end
    endtask

    // Random receiver back-pressure.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Output checker: each accepted word against the oldest expectation.
    always @(posedge clk)
    begin : check_words
        rate_t want;
        rate_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{ok: m_axis_tuser[0], bps: m_axis_tdata[31:0], kbps: m_axis_tdata[63:32]};
            if (want_wr == want_rd)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected word: valid=%0d bps=%0d kbps=%0d",
                             got.ok, got.bps, got.kbps);
                end
            end
            else
            begin
                want = want_fifo[want_rd];
                want_rd++;
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("word mismatch: valid %0d/%0d bps %0d/%0d kbps %0d/%0d",
                                 want.ok, got.ok, want.bps, got.bps, want.kbps, got.kbps);
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed rows, then randomized phases.
    initial
    begin : main_seq
        bit prev_cfg;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset state with a zero window: every word drops at once and nothing is valid.
        add_meas(32'd0, 32'd0, 48'd0, 1, 1'b0, 32'd0, 32'd0);
        add_meas(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd5, 1, 1'b0, 32'd0, 32'd0);
        // Time going backwards.
        add_meas(32'd1, 32'd1, 48'd3, 1, 1'b0, 32'd0, 32'd0);
        add_cfg(swbe_pkg::REG_WINDOW, 16'd63);
        add_cfg(swbe_pkg::REG_PERIOD, 16'd65535);
        add_meas(32'hFFFF_FFFF, 32'd0, 48'hFFFF_FFFF_FFFF, 1, 1'b0, 32'd0, 32'd0);
        // Zero window duration, then a saturated bps value.
        add_meas(32'd0, 32'd0, 48'd10, 1, 1'b1, 32'hFFFF_FFFF, 32'd0);
        add_meas(32'hFFFF_FFFF, 32'd1, 48'd20, 1, 1'b1, 32'hFFFF_FFFF, 32'd0);
        // Shrink the window below the count; kbps overflow and zero divisor follow.
        add_cfg(swbe_pkg::REG_WINDOW, 16'd2);
        add_cfg(swbe_pkg::REG_PERIOD, 16'd0);
        add_meas(32'd100, 32'd1000, 48'd30, 0, 1'b0, 32'd0, 32'd0);
        add_meas(32'd5, 32'd0, 48'd40, 0, 1'b0, 32'd0, 32'd0);
        add_meas(32'd5, 32'd0, 48'd50, 0, 1'b0, 32'd0, 32'd0);
        add_meas(32'd5, 32'd0, 48'd60, 0, 1'b0, 32'd0, 32'd0);
        add_meas(32'd40000, 32'd300000, 48'd100000, 0, 1'b0, 32'd0, 32'd0);
        add_meas(32'd60000, 32'd250000, 48'd150000, 0, 1'b0, 32'd0, 32'd0);
        // One millisecond period: first word inside it, second just at it.
        add_cfg(swbe_pkg::REG_PERIOD, 16'd1);
        add_meas(32'd30000, 32'd200000, 48'd150500, 0, 1'b0, 32'd0, 32'd0);
        add_meas(32'd20000, 32'd100000, 48'd151000, 0, 1'b0, 32'd0, 32'd0);
        add_meas(32'd7, 32'd999, 48'd152000, 0, 1'b0, 32'd0, 32'd0);

        set_mode(IDLE_BOTH);
        prev_cfg = 1'b0;
        for (int i = 0; i < plan_len; i++)
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                if (!prev_cfg)
                begin
                    drain();
                end
                write_reg(plan[i].reg_sel, plan[i].reg_val);
                prev_cfg = 1'b1;
            end
            else
            begin
                send_meas(plan[i].m, plan[i].typed, plan[i].want);
                prev_cfg = 1'b0;
            end
        end

        clock_us = 48'd1000000;
        foreach (phases[p])
        begin
            drain();
            write_reg(swbe_pkg::REG_WINDOW, {10'd0, phases[p].window});
            write_reg(swbe_pkg::REG_PERIOD, phases[p].period);
            set_mode(phases[p].mode);
            repeat (phases[p].items)
            begin
                send_meas(make_meas(), 1'b0, '0);
            end
        end

        drain();
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && want_wr == want_rd)
        begin
            $display("sliding_window_bandwidth_estimator_core: match");
        end
        else
        begin
            $display("sliding_window_bandwidth_estimator_core: mismatch");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #40_000_000;
        $display("sliding_window_bandwidth_estimator_core: mismatch");
        $finish;
    end

endmodule
